FILE: rtl/core/prpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpd_pkg
// Shared types, widths, constants and the glyph table for the point
// rotate / project / depth-test block.
// ----------------------------------------------------------------------------
package prpd_pkg;

  // store geometry defaults
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 64;

  // datapath widths
  localparam int ROT_W = 24;   // rotated coordinates and w
  localparam int MB_W  = 17;   // multiplier B operand
  localparam int PRD_W = ROT_W + MB_W;
  localparam int ACC_W = 44;
  localparam int NUM_W = 44;   // divider numerator
  localparam int DEN_W = 31;   // divider denominator
  localparam int QUO_W = 17;   // divider quotient bits
  localparam int SH_W  = DEN_W + QUO_W;

  localparam logic [15:0] FAR_DEPTH  = 16'hFFFF;
  localparam logic [2:0]  BLANK_CODE = 3'd6;
  localparam logic [7:0]  SPACE_CHAR = 8'h20;

  // sequencer
  localparam logic [4:0] LAST_STEP = 5'd17;

  // result status codes
  localparam logic [1:0] STAT_DRAWN  = 2'd0;
  localparam logic [1:0] STAT_HIDDEN = 2'd1;
  localparam logic [1:0] STAT_OFF    = 2'd2;
  localparam logic [1:0] STAT_READ   = 2'd3;

  // commands
  localparam logic CMD_PLOT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register indexes
  localparam logic [2:0] CFG_SIN  = 3'd0;
  localparam logic [2:0] CFG_COS  = 3'd1;
  localparam logic [2:0] CFG_ZOFF = 3'd2;
  localparam logic [2:0] CFG_XSC  = 3'd3;
  localparam logic [2:0] CFG_YSC  = 3'd4;
  localparam logic [2:0] CFG_COLS = 3'd5;
  localparam logic [2:0] CFG_ROWS = 3'd6;

  // register reset values
  localparam logic [15:0] SIN_RST  = 16'd0;
  localparam logic [15:0] COS_RST  = 16'd16384;
  localparam logic [15:0] ZOFF_RST = 16'd5120;
  localparam logic [15:0] XSC_RST  = 16'd9984;
  localparam logic [15:0] YSC_RST  = 16'd4004;
  localparam logic [8:0]  COLS_RST = 9'd80;
  localparam logic [6:0]  ROWS_RST = 7'd24;

  typedef enum logic [3:0] {
    MA_X, MA_Y, MA_Z, MA_Z1, MA_X2, MA_Y1, MA_X3, MA_Y3, MA_W
  } mula_t;

  typedef enum logic [2:0] {
    MB_C, MB_S, MB_XS, MB_YS, MB_COLS, MB_ROWS
  } mulb_t;

  typedef enum logic [2:0] {
    AC_NONE, AC_LOAD, AC_ADD, AC_SUB, AC_LOAD8, AC_ADD2, AC_SUB2
  } accop_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_Y1, WR_Z1, WR_X2, WR_Z2, WR_X3, WR_Y3
  } wr_t;

  typedef enum logic {
    DV_CR, DV_DEP
  } divsel_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CALC, ST_DIV_COL, ST_DIV_ROW, ST_DIV_DEP,
    ST_MEM_RD, ST_MEM_CMP, ST_DONE
  } state_t;

  typedef struct packed {
    mula_t   mul_a;
    mulb_t   mul_b;
    accop_t  acc_op;
    wr_t     wr;
    logic    div_start;
    divsel_t div_sel;
    logic    cap_col;
    logic    cap_row;
    logic    cap_dep;
    logic    take_in;
    logic    clear;
    logic    mem_rd;
    logic    mem_commit;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_read;
    logic w_pos;
    logic div_done;
    logic on_screen;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] glyph(input logic [2:0] code);
    logic [7:0] g;
    case (code)
      3'd0:    g = 8'h3E;  // >
      3'd1:    g = 8'h3D;  // =
      3'd2:    g = 8'h21;  // !
      3'd3:    g = 8'h2A;  // *
      3'd4:    g = 8'h24;  // $
      3'd5:    g = 8'h40;  // @
      default: g = SPACE_CHAR;
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/core/point_rotate_project_depth_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_project_depth_test
// Rotates a Q8.8 point about x, y and z, projects it by its depth w onto a
// character screen and keeps it only where it is nearer than the stored
// depth. A read beat returns one pixel's symbol and clears that pixel.
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid / tready    tuser: command; tdata: point, face, read pos
//  m_axis    out  tvalid / tready    tuser: status;  tdata: col, row, depth, symbol
//  cfg       in   cfg_valid / ready  cfg_index, cfg_data (ready always high)
//
// Plot beat: a shared multiply/accumulate sequence, then three radix-2
// divider runs (column, row, depth) of 17 quotient bits each, the column run
// overlapping the last accumulate step, then a store read-modify-write and
// the hand-off. Points off screen skip the store; points with w <= 0 go
// from the accumulate steps straight to the hand-off.
// Read beat: a registered store read, the write-back and the hand-off.
// After reset a clearing pass writes every store entry, one per cycle
// (2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries, 16384 by default); no beat
// is taken meanwhile. One result waits in the output register while the
// next beat is accepted; a stalled m_axis holds only the final hand-off.
// ----------------------------------------------------------------------------
module point_rotate_project_depth_test
  import prpd_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x[15:0] point_y[31:16] point_z[47:32] face[50:48]
  // read_col[58:51] read_row[64:59] zero[71:65]
  input  logic [71:0] s_axis_tdata,
  // command[0]
  input  logic [0:0]  s_axis_tuser,
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_col[7:0] out_row[13:8] depth[29:14] symbol[37:30] zero[39:38]
  output logic [39:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // registers are to change only while idle (the user's duty, not enforced here); writes are always taken
  assign cfg_ready = 1'b1;

  prpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prpd_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: rtl/core/prpd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpd_div
// Restoring divider, one quotient bit per cycle, with an overflow flag for
// quotients that do not fit.
// ----------------------------------------------------------------------------
module prpd_div
  import prpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quot,
  output logic             ovf
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] rem;
  logic [SH_W-1:0]  dsh;
  logic             ge;

  assign ge = SH_W'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(QUO_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= SH_W'({den, {(QUO_W-1){1'b0}}});
      quot <= '0;
      ovf  <= SH_W'(num) >= {den, {QUO_W{1'b0}}};
    end else if (cnt != '0) begin
      if (ge) begin
        rem <= rem - dsh[NUM_W-1:0];
      end
      dsh  <= dsh >> 1;
      quot <= {quot[QUO_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/core/prpd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpd_datapath
// Config registers, shared multiplier and accumulator, divider, pixel
// store and output register.
// ----------------------------------------------------------------------------
module prpd_datapath
  import prpd_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [71:0] s_tdata,
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  localparam int CWD = $clog2(MAX_COLS);
  localparam int RWD = $clog2(MAX_ROWS);
  localparam int AW  = CWD + RWD;
  localparam logic [10:0] COL_MAX = 11'(MAX_COLS);
  localparam logic [9:0]  ROW_MAX = 10'(MAX_ROWS);

  // config
  logic signed [15:0] sin_r, cos_r, zoff_r;
  logic [15:0] xsc_r, ysc_r;
  logic [8:0]  cols_r;
  logic [6:0]  rows_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      sin_r  <= SIN_RST;
      cos_r  <= COS_RST;
      zoff_r <= ZOFF_RST;
      xsc_r  <= XSC_RST;
      ysc_r  <= YSC_RST;
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SIN:  sin_r  <= cfg_data;
        CFG_COS:  cos_r  <= cfg_data;
        CFG_ZOFF: zoff_r <= cfg_data;
        CFG_XSC:  xsc_r  <= cfg_data;
        CFG_YSC:  ysc_r  <= cfg_data;
        CFG_COLS: cols_r <= cfg_data[8:0];
        CFG_ROWS: rows_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // latched input beat
  logic               is_read;
  logic signed [15:0] px, py, pz;
  logic [2:0]         face;
  logic [7:0]         rc;
  logic [5:0]         rr;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      is_read <= s_tuser[0];
      px      <= s_tdata[15:0];
      py      <= s_tdata[31:16];
      pz      <= s_tdata[47:32];
      face    <= s_tdata[50:48];
      rc      <= s_tdata[58:51];
      rr      <= s_tdata[64:59];
    end
  end

  // multiply / accumulate
  logic signed [ROT_W-1:0] y1, z1, x2, z2, x3, y3, w;
  logic signed [ROT_W-1:0] ma;
  logic signed [MB_W-1:0]  mb;
  logic signed [PRD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc, pe, rnd;
  logic [ROT_W-1:0]        rot_val;

  always_comb begin
    case (cmd.mul_a)
      MA_X:    ma = ROT_W'(px);
      MA_Y:    ma = ROT_W'(py);
      MA_Z:    ma = ROT_W'(pz);
      MA_Z1:   ma = z1;
      MA_X2:   ma = x2;
      MA_Y1:   ma = y1;
      MA_X3:   ma = x3;
      MA_Y3:   ma = y3;
      MA_W:    ma = w;
      default: ma = '0;
    endcase
    case (cmd.mul_b)
      MB_C:    mb = MB_W'(cos_r);
      MB_S:    mb = MB_W'(sin_r);
      MB_XS:   mb = signed'({1'b0, xsc_r});
      MB_YS:   mb = signed'({1'b0, ysc_r});
      MB_COLS: mb = signed'(MB_W'(cols_r));
      MB_ROWS: mb = signed'(MB_W'(rows_r));
      default: mb = '0;
    endcase
  end

  assign pe      = ACC_W'(prod);
  // divide by 2^14, half away from zero
  assign rnd     = acc + (acc[ACC_W-1] ? ACC_W'(8191) : ACC_W'(8192));
  assign rot_val = rnd[ROT_W+13:14];
  assign w       = z2 + ROT_W'(zoff_r);

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.acc_op)
      AC_LOAD:  acc <= pe;
      AC_ADD:   acc <= acc + pe;
      AC_SUB:   acc <= acc - pe;
      AC_LOAD8: acc <= pe <<< 8;
      AC_ADD2:  acc <= acc + (pe <<< 1);
      AC_SUB2:  acc <= acc - (pe <<< 1);
      default: ;
    endcase
    case (cmd.wr)
      WR_Y1:   y1 <= rot_val;
      WR_Z1:   z1 <= rot_val;
      WR_X2:   x2 <= rot_val;
      WR_Z2:   z2 <= rot_val;
      WR_X3:   x3 <= rot_val;
      WR_Y3:   y3 <= rot_val;
      default: ;
    endcase
  end

  // divider operands
  logic              w_pos;
  logic [ROT_W-1:0]  w_u;
  logic [NUM_W-1:0]  acc_mag, div_num;
  logic [DEN_W-1:0]  div_den;
  logic signed [29:0] w30, w29, w25, dt;
  logic              dpos;
  logic              div_done, div_ovf;
  logic [QUO_W-1:0]  div_q;

  assign w_pos   = !w[ROT_W-1] && (w != '0);
  assign w_u     = w;
  assign acc_mag = acc[ACC_W-1] ? NUM_W'(-acc) : NUM_W'(acc);
  assign w30     = 30'(w);
  assign w29     = (w30 <<< 5) - (w30 <<< 1) - w30;
  assign w25     = (w30 <<< 4) + (w30 <<< 3) + w30;
  assign dt      = w29 - 30'sd29696;
  assign dpos    = dt > 30'sd0;

  always_comb begin
    case (cmd.div_sel)
      DV_CR: begin
        div_num = acc_mag + (NUM_W'(w_u) << 8);
        div_den = DEN_W'(w_u) << 9;
      end
      default: begin
        div_num = {dt[NUM_W-17:0], 16'b0} + NUM_W'(w25[29:1]);
        div_den = DEN_W'(w25[29:0]);
      end
    endcase
  end

  prpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q),
    .ovf   (div_ovf)
  );

  // projected position and depth
  logic             col_neg, row_neg, col_ovf, row_ovf;
  logic [QUO_W-1:0] col_q, row_q, col_v, row_v;
  logic [15:0]      dep_r;
  logic [10:0]      cols_ext, col_lim;
  logic [9:0]       rows_ext, row_lim;
  logic             col_ok, row_ok, on_screen;

  always_ff @(posedge clk) begin
    if (cmd.div_start && cmd.div_sel == DV_CR) begin
      if (cmd.cap_col) begin
        row_neg <= acc[ACC_W-1];
      end else begin
        col_neg <= acc[ACC_W-1];
      end
    end
    if (cmd.cap_col) begin
      col_q   <= div_q;
      col_ovf <= div_ovf;
    end
    if (cmd.cap_row) begin
      row_q   <= div_q;
      row_ovf <= div_ovf;
    end
    if (cmd.cap_dep) begin
      if (!dpos) begin
        dep_r <= '0;
      end else if (div_ovf || div_q[QUO_W-1:16] != '0) begin
        dep_r <= FAR_DEPTH;
      end else begin
        dep_r <= div_q[15:0];
      end
    end
  end

  assign cols_ext  = 11'(cols_r);
  assign rows_ext  = 10'(rows_r);
  assign col_lim   = (cols_ext > COL_MAX) ? COL_MAX : cols_ext;
  assign row_lim   = (rows_ext > ROW_MAX) ? ROW_MAX : rows_ext;
  // a negative quotient that rounds to zero lands on column or row 0
  assign col_v     = col_neg ? '0 : col_q;
  assign row_v     = row_neg ? '0 : row_q;
  assign col_ok    = !col_ovf && (!col_neg || col_q == '0) && (col_v < QUO_W'(col_lim));
  assign row_ok    = !row_ovf && (!row_neg || row_q == '0) && (row_v < QUO_W'(row_lim));
  assign on_screen = col_ok && row_ok;

  // pixel store: {depth, symbol code}
  logic [18:0]   mem [2**AW];
  logic [18:0]   rd_q, wdata;
  logic [AW-1:0] clr_addr, addr, waddr;
  logic          in_store, hit, we;

  assign in_store = ({24'b0, rc} < 32'(MAX_COLS)) && ({26'b0, rr} < 32'(MAX_ROWS));
  assign addr     = is_read ? {RWD'(rr), CWD'(rc)} : {RWD'(row_v), CWD'(col_v)};
  assign hit      = rd_q[18:3] > dep_r;
  assign we       = cmd.clear || (cmd.mem_commit && (is_read ? in_store : hit));
  assign waddr    = cmd.clear ? clr_addr : addr;
  assign wdata    = (cmd.clear || is_read) ? {FAR_DEPTH, BLANK_CODE} : {dep_r, face};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rd_q <= mem[addr];
    end
  end

  // result beat
  logic [1:0]  r_status;
  logic [7:0]  r_col, r_sym;
  logic [5:0]  r_row;
  logic [15:0] r_dep;

  always_comb begin
    r_status = STAT_OFF;
    r_col    = '0;
    r_row    = '0;
    r_dep    = '0;
    r_sym    = '0;
    if (is_read) begin
      r_status = STAT_READ;
      r_col    = rc;
      r_row    = rr;
      r_dep    = in_store ? rd_q[18:3] : FAR_DEPTH;
      r_sym    = in_store ? glyph(rd_q[2:0]) : SPACE_CHAR;
    end else if (w_pos) begin
      r_dep = dep_r;
      if (on_screen) begin
        r_status = hit ? STAT_DRAWN : STAT_HIDDEN;
        r_col    = col_v[7:0];
        r_row    = row_v[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {2'b0, r_sym, r_dep, r_row, r_col};
      m_tuser <= r_status;
    end
  end

  assign stat.clr_last  = &clr_addr;
  assign stat.in_read   = s_tuser[0] == CMD_READ;
  assign stat.w_pos     = w_pos;
  assign stat.div_done  = div_done;
  assign stat.on_screen = on_screen;
  assign stat.out_free  = !m_tvalid || m_tready;

endmodule

FILE: rtl/core/prpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpd_ctrl
// Controller: store clear, rotation/projection sequence, divider hand-off,
// store read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
module prpd_ctrl
  import prpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t     state, state_next;
  logic [4:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign in_ready = state == ST_IDLE;

  // next state
  always_comb begin
    state_next = state;
    step_next  = '0;
    case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = stat.in_read ? ST_MEM_RD : ST_CALC;
      end
      ST_CALC: begin
        step_next = step + 1'b1;
        if (step == LAST_STEP) begin
          step_next  = '0;
          state_next = stat.w_pos ? ST_DIV_COL : ST_DONE;
        end
      end
      ST_DIV_COL: begin
        if (stat.div_done) state_next = ST_DIV_ROW;
      end
      ST_DIV_ROW: begin
        if (stat.div_done) state_next = ST_DIV_DEP;
      end
      ST_DIV_DEP: begin
        if (stat.div_done) state_next = stat.on_screen ? ST_MEM_RD : ST_DONE;
      end
      ST_MEM_RD:  state_next = ST_MEM_CMP;
      ST_MEM_CMP: state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE:  cmd.take_in = in_valid;
      ST_CALC: begin
        // product issued one step ahead of the accumulate that uses it
        case (step)
          5'd0:  begin cmd.mul_a = MA_Y;  cmd.mul_b = MB_C; end
          5'd1:  begin cmd.mul_a = MA_Z;  cmd.mul_b = MB_S; cmd.acc_op = AC_LOAD; end
          5'd2:  begin cmd.mul_a = MA_Z;  cmd.mul_b = MB_C; cmd.acc_op = AC_ADD; end
          5'd3:  begin
            cmd.mul_a = MA_Y; cmd.mul_b = MB_S; cmd.acc_op = AC_LOAD; cmd.wr = WR_Y1;
          end
          5'd4:  begin cmd.mul_a = MA_X;  cmd.mul_b = MB_C; cmd.acc_op = AC_SUB; end
          5'd5:  begin cmd.acc_op = AC_LOAD; cmd.wr = WR_Z1; end
          5'd6:  begin cmd.mul_a = MA_Z1; cmd.mul_b = MB_S; end
          5'd7:  begin cmd.mul_a = MA_X;  cmd.mul_b = MB_S; cmd.acc_op = AC_SUB; end
          5'd8:  begin
            cmd.mul_a = MA_Z1; cmd.mul_b = MB_C; cmd.acc_op = AC_LOAD; cmd.wr = WR_X2;
          end
          5'd9:  begin cmd.mul_a = MA_X2; cmd.mul_b = MB_C; cmd.acc_op = AC_ADD; end
          5'd10: begin
            cmd.mul_a = MA_Y1; cmd.mul_b = MB_S; cmd.acc_op = AC_LOAD; cmd.wr = WR_Z2;
          end
          5'd11: begin cmd.mul_a = MA_Y1; cmd.mul_b = MB_C; cmd.acc_op = AC_ADD; end
          5'd12: begin
            cmd.mul_a = MA_X2; cmd.mul_b = MB_S; cmd.acc_op = AC_LOAD; cmd.wr = WR_X3;
          end
          5'd13: begin cmd.mul_a = MA_W;  cmd.mul_b = MB_COLS; cmd.acc_op = AC_SUB; end
          5'd14: begin
            cmd.mul_a = MA_X3; cmd.mul_b = MB_XS; cmd.acc_op = AC_LOAD8; cmd.wr = WR_Y3;
          end
          5'd15: begin cmd.mul_a = MA_W;  cmd.mul_b = MB_ROWS; cmd.acc_op = AC_ADD2; end
          5'd16: begin
            cmd.mul_a     = MA_Y3;
            cmd.mul_b     = MB_YS;
            cmd.acc_op    = AC_LOAD8;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DV_CR;
          end
          5'd17: cmd.acc_op = AC_SUB2;
          default: ;
        endcase
      end
      ST_DIV_COL: begin
        cmd.cap_col   = stat.div_done;
        cmd.div_start = stat.div_done;
        cmd.div_sel   = DV_CR;
      end
      ST_DIV_ROW: begin
        cmd.cap_row   = stat.div_done;
        cmd.div_start = stat.div_done;
        cmd.div_sel   = DV_DEP;
      end
      ST_DIV_DEP: begin
        cmd.cap_dep = stat.div_done;
        cmd.div_sel = DV_DEP;
      end
      ST_MEM_RD:  cmd.mem_rd = 1'b1;
      ST_MEM_CMP: cmd.mem_commit = 1'b1;
      ST_DONE:    cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != ST_IDLE)
    else $error("accepted beat did not start work");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("result overwrote a waiting beat");

  a_clear_no_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.mem_commit && !in_ready)
    else $error("store commit during clear pass");

  a_div_done_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !stat.div_done)
    else $error("divider done too early");

endmodule
